FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Shared assertion macros for the frame engine.
// ASSERT_AT checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// ASSERT_IMPL checks that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_AT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: design/mrfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_pkg
// Types, codes and the CRC-16 step shared by the frame engine modules.
// ----------------------------------------------------------------------------
package mrfe_pkg;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_BYTE    = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  // Classified commands handed from the front end to the sequencer.
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_BYTE    = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT = 3'd3;
  localparam logic [2:0] CMD_BADCNT  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_BAD_HDR   = 3'd3;
  localparam logic [2:0] ST_ECHO      = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT = 3'd5;

  localparam logic [7:0]  FC_READ  = 8'h03;
  localparam logic [7:0]  FC_WRITE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int STORE_DEPTH = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] reg_addr;
    logic [15:0] word;
    logic [7:0]  rx_byte;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [3:0]  word_index;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // One byte of the reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: design/mrfe_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe channels
// Valid/ready channel interfaces for command beats and result beats.
// ----------------------------------------------------------------------------
interface mrfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] reg_addr;
  logic [15:0] word;
  logic [7:0]  rx_byte;

  modport source (output valid, opcode, reg_addr, word, rx_byte, input ready);
  modport sink (input valid, opcode, reg_addr, word, rx_byte, output ready);
endinterface

interface mrfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] reg_word;
  logic [3:0]  word_index;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, tx_byte, reg_word, word_index, status, last,
                  input ready);
  modport sink (input valid, kind, tx_byte, reg_word, word_index, status, last,
                output ready);
endinterface

FILE: design/mrfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_front
// Accepts input beats, classifies them into commands and registers them.
// ----------------------------------------------------------------------------
module mrfe_front #(
  parameter int MAX_WORDS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  mrfe_in_if.sink         in_bus,
  output mrfe_pkg::entry_t ent,
  output logic            ent_valid,
  input  logic            ent_ready
);
  import mrfe_pkg::*;

  localparam int          WORD_LIMIT = (MAX_WORDS < STORE_DEPTH) ? MAX_WORDS : STORE_DEPTH;
  localparam logic [15:0] LIMIT      = 16'(WORD_LIMIT);

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;
  logic   take;
  logic [2:0] cmd;

  assign in_bus.ready = !valid_r || ent_ready;
  assign take         = in_bus.valid && in_bus.ready;
  assign ent          = ent_r;
  assign ent_valid    = valid_r;

  // A read with a zero count or one beyond MAX_WORDS or the word store is classed here as a bad count.
  always_comb begin
    case (in_bus.opcode)
      OP_READ: begin
        cmd = ((in_bus.word == 16'd0) || (in_bus.word > LIMIT)) ? CMD_BADCNT : CMD_READ;
      end
      OP_WRITE:   cmd = CMD_WRITE;
      OP_BYTE:    cmd = CMD_BYTE;
      OP_TIMEOUT: cmd = CMD_TIMEOUT;
      default:    cmd = CMD_TIMEOUT;
    endcase
  end

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    if (take) begin
      ent_nxt.cmd      = cmd;
      ent_nxt.reg_addr = in_bus.reg_addr;
      ent_nxt.word     = in_bus.word;
      ent_nxt.rx_byte  = in_bus.rx_byte;
      valid_nxt        = 1'b1;
    end else if (ent_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: design/mrfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_queue
// Short command queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrfe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mrfe_pkg::entry_t push_ent,
  input  logic             push_valid,
  output logic             push_ready,
  output mrfe_pkg::entry_t pop_ent,
  output logic             pop_valid,
  input  logic             pop_ready
);
  import mrfe_pkg::*;

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_ent    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  `ASSERT_AT(a_q_no_overfill, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_IMPL(a_q_empty_ptrs, clk, rst_n, count_r == '0,
               wr_ptr_r == rd_ptr_r, "empty queue with split pointers")

endmodule

FILE: design/mrfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_back
// Sequencer: sends requests, checks responses and emits result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrfe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  mrfe_pkg::entry_t ent,
  input  logic             ent_valid,
  output logic             ent_ready,
  mrfe_out_if.source       out_bus
);
  import mrfe_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TX    = 2'd1;
  localparam logic [1:0] S_WORDS = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  exp_len_r, exp_len_nxt;
  logic [5:0]  rcv_cnt_r, rcv_cnt_nxt;
  logic [4:0]  word_cnt_r, word_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic        crc_ok_r, crc_ok_nxt;
  logic        echo_ok_r, echo_ok_nxt;
  logic [7:0]  dev_addr_r, dev_addr_nxt;
  logic [4:0]  idx_r, idx_nxt;
  result_t     res_r, res_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic [7:0]  req_r [8];
  logic [7:0]  req_nxt [8];
  logic [15:0] words_r [STORE_DEPTH];
  logic [15:0] words_nxt [STORE_DEPTH];

  logic        out_free, take;
  logic [2:0]  req_addr;
  logic [7:0]  req_rd;
  logic [7:0]  tx_byte;
  logic [6:0]  pos_p2;
  logic [5:0]  off;
  logic [3:0]  widx;
  logic        done;
  logic        emit;
  result_t     beat;

  assign out_free  = !res_valid_r || out_bus.ready;
  assign ent_ready = (state_r == S_IDLE) && out_free;
  assign take      = ent_ready && ent_valid;

  // One read port on the request bytes: transmit index or echo position.
  assign req_addr = (state_r == S_TX) ? idx_r[2:0] : rcv_cnt_r[2:0];
  assign req_rd   = req_r[req_addr];
  assign pos_p2   = {1'b0, rcv_cnt_r} + 7'd2;
  assign off      = rcv_cnt_r - 6'd3;
  assign widx     = off[4:1];

  always_comb begin
    case (idx_r[2:0])
      3'd6:    tx_byte = crc_r[7:0];
      3'd7:    tx_byte = crc_r[15:8];
      default: tx_byte = req_rd;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    rcv_cnt_nxt  = rcv_cnt_r;
    word_cnt_nxt = word_cnt_r;
    crc_nxt      = crc_r;
    hdr_ok_nxt   = hdr_ok_r;
    crc_ok_nxt   = crc_ok_r;
    echo_ok_nxt  = echo_ok_r;
    dev_addr_nxt = cfg_we ? cfg_wdata : dev_addr_r;
    idx_nxt      = idx_r;
    req_nxt      = req_r;
    words_nxt    = words_r;
    done         = 1'b0;
    emit         = 1'b0;
    beat         = '0;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (ent.cmd)
            CMD_READ, CMD_WRITE: begin
              req_nxt[0]  = dev_addr_r;
              req_nxt[1]  = (ent.cmd == CMD_READ) ? FC_READ : FC_WRITE;
              req_nxt[2]  = ent.reg_addr[15:8];
              req_nxt[3]  = ent.reg_addr[7:0];
              req_nxt[4]  = ent.word[15:8];
              req_nxt[5]  = ent.word[7:0];
              crc_nxt     = CRC_INIT;
              rcv_cnt_nxt = '0;
              hdr_ok_nxt  = 1'b1;
              crc_ok_nxt  = 1'b1;
              echo_ok_nxt = 1'b1;
              idx_nxt     = '0;
              state_nxt   = S_TX;
              if (ent.cmd == CMD_READ) begin
                phase_nxt    = PH_READ;
                word_cnt_nxt = ent.word[4:0];
                exp_len_nxt  = 6'd5 + {ent.word[4:0], 1'b0};
              end else begin
                phase_nxt    = PH_WRITE;
                word_cnt_nxt = '0;
                exp_len_nxt  = 6'd8;
              end
            end
            CMD_BADCNT: begin
              phase_nxt   = PH_IDLE;
              emit        = 1'b1;
              beat.kind   = KIND_STATUS;
              beat.status = ST_BAD_COUNT;
              beat.last   = 1'b1;
            end
            CMD_TIMEOUT: begin
              if (phase_r != PH_IDLE) begin
                phase_nxt   = PH_IDLE;
                emit        = 1'b1;
                beat.kind   = KIND_STATUS;
                beat.status = ST_TIMEOUT;
                beat.last   = 1'b1;
              end
            end
            CMD_BYTE: begin
              if (phase_r != PH_IDLE) begin
                if (phase_r == PH_WRITE) begin
                  if (req_rd != ent.rx_byte) begin
                    echo_ok_nxt = 1'b0;
                  end
                end else if (pos_p2 < {1'b0, exp_len_r}) begin
                  crc_nxt = crc_feed(crc_r, ent.rx_byte);
                  if ((rcv_cnt_r == 6'd0) && (ent.rx_byte != dev_addr_r)) begin
                    hdr_ok_nxt = 1'b0;
                  end
                  if ((rcv_cnt_r == 6'd1) && (ent.rx_byte != FC_READ)) begin
                    hdr_ok_nxt = 1'b0;
                  end
                  if (rcv_cnt_r >= 6'd3) begin
                    if (!off[0]) begin
                      words_nxt[widx] = {ent.rx_byte, 8'h00};
                    end else begin
                      words_nxt[widx] = words_r[widx] | {8'h00, ent.rx_byte};
                    end
                  end
                end else if (pos_p2 == {1'b0, exp_len_r}) begin
                  if (ent.rx_byte != crc_r[7:0]) begin
                    crc_ok_nxt = 1'b0;
                  end
                end else begin
                  if (ent.rx_byte != crc_r[15:8]) begin
                    crc_ok_nxt = 1'b0;
                  end
                end
                rcv_cnt_nxt = rcv_cnt_r + 6'd1;
                done        = (rcv_cnt_nxt >= exp_len_r);
                if (done) begin
                  phase_nxt = PH_IDLE;
                  beat.kind = KIND_STATUS;
                  beat.last = 1'b1;
                  if (phase_r == PH_WRITE) begin
                    emit        = 1'b1;
                    beat.status = echo_ok_nxt ? ST_OK : ST_ECHO;
                  end else if (!crc_ok_nxt) begin
                    emit        = 1'b1;
                    beat.status = ST_CRC;
                  end else if (!hdr_ok_nxt) begin
                    emit        = 1'b1;
                    beat.status = ST_BAD_HDR;
                  end else begin
                    idx_nxt   = '0;
                    state_nxt = S_WORDS;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TX: begin
        if (out_free) begin
          emit         = 1'b1;
          beat.kind    = KIND_TX;
          beat.tx_byte = tx_byte;
          beat.last    = (idx_r == 5'd7);
          idx_nxt      = idx_r + 5'd1;
          if (idx_r < 5'd6) begin
            crc_nxt = crc_feed(crc_r, tx_byte);
          end else if (idx_r == 5'd6) begin
            req_nxt[6] = tx_byte;
          end else begin
            req_nxt[7] = tx_byte;
            crc_nxt    = CRC_INIT;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_WORDS: begin
        if (out_free) begin
          emit = 1'b1;
          if (idx_r < word_cnt_r) begin
            beat.kind       = KIND_WORD;
            beat.reg_word   = words_r[idx_r[3:0]];
            beat.word_index = idx_r[3:0];
            idx_nxt         = idx_r + 5'd1;
          end else begin
            beat.kind   = KIND_STATUS;
            beat.status = ST_OK;
            beat.last   = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      res_nxt       = beat;
      res_valid_nxt = 1'b1;
    end else begin
      res_nxt       = res_r;
      res_valid_nxt = res_valid_r && !out_bus.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      exp_len_r   <= '0;
      rcv_cnt_r   <= '0;
      word_cnt_r  <= '0;
      crc_r       <= CRC_INIT;
      hdr_ok_r    <= 1'b0;
      crc_ok_r    <= 1'b0;
      echo_ok_r   <= 1'b0;
      dev_addr_r  <= 8'd1;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      exp_len_r   <= exp_len_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      word_cnt_r  <= word_cnt_nxt;
      crc_r       <= crc_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      crc_ok_r    <= crc_ok_nxt;
      echo_ok_r   <= echo_ok_nxt;
      dev_addr_r  <= dev_addr_nxt;
      idx_r       <= idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    req_r   <= req_nxt;
    words_r <= words_nxt;
  end

  assign out_bus.valid      = res_valid_r;
  assign out_bus.kind       = res_r.kind;
  assign out_bus.tx_byte    = res_r.tx_byte;
  assign out_bus.reg_word   = res_r.reg_word;
  assign out_bus.word_index = res_r.word_index;
  assign out_bus.status     = res_r.status;
  assign out_bus.last       = res_r.last;

  `ASSERT_IMPL(a_tx_has_phase, clk, rst_n, state_r == S_TX,
               phase_r != PH_IDLE, "request sent with no transaction open")
  `ASSERT_IMPL(a_words_in_range, clk, rst_n, state_r == S_WORDS,
               idx_r <= word_cnt_r, "word index past the read count")

endmodule

FILE: design/modbus_rtu_master_frame_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine_top
// Modbus RTU master framing for read holding registers and write single
// register, with response checking.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake      Beat contents
//   in_bus    in   valid/ready    opcode, reg_addr, word, rx_byte
//   out_bus   out  valid/ready    kind, tx_byte, reg_word, word_index, status, last
//   cfg_*     in   write enable   device_address (8 bits)
//
// An accepted command beat reaches the sequencer through the front register
// and then the command queue.
// The sequencer issues at most one result beat per cycle and holds while a result
// beat is stalled: a request is loaded and then sent as eight byte beats, a received
// byte is taken in, and a good read response gives one beat per register word plus the status.
// Reset is synchronous and active low; the device address returns to 1.
// A stalled result beat holds the sequencer; the queue then fills, the front register
// holds and in_bus.ready deasserts. Beats on in_bus keep flowing while the queue has room.
//
module modbus_rtu_master_frame_engine_top #(
  parameter int MAX_WORDS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mrfe_in_if.sink    in_bus,
  mrfe_out_if.source out_bus,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mrfe_pkg::*;

  // Front register to queue.
  entry_t front_ent;
  logic   front_valid;
  logic   front_ready;

  // Queue head to sequencer.
  entry_t head_ent;
  logic   head_valid;
  logic   head_ready;

  // The front end classifies each beat and flags bad read counts early.
  mrfe_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .ent      (front_ent),
    .ent_valid(front_valid),
    .ent_ready(front_ready)
  );

  // The queue decouples intake from the sequencer while it streams results.
  mrfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_ent  (front_ent),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .pop_ent   (head_ent),
    .pop_valid (head_valid),
    .pop_ready (head_ready)
  );

  // The sequencer holds all transaction state and the output register.
  mrfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .ent      (head_ent),
    .ent_valid(head_valid),
    .ent_ready(head_ready),
    .out_bus  (out_bus)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU master frame engine. A short table of
// hand-picked beats covers reset values, bad counts, idle traffic, abandoned
// transactions and error priority. Random read and write exchanges follow,
// mostly well formed, some corrupted or cut short. Results are checked against a
// behavioral model of the master kept inside this bench, or typed-in table values.
// ----------------------------------------------------------------------------
module testbench;
  import mrfe_pkg::*;

  localparam int MAX_WORDS   = 16;
  localparam int WORD_LIMIT  = (MAX_WORDS < STORE_DEPTH) ? MAX_WORDS : STORE_DEPTH;
  // A good 16-word read costs 17 result beats, the passage through the front register
  // and queue, and the time for the result side to work through its backlog.
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 84;

  // Transaction state of the master, as the bench tracks it.
  typedef enum logic [1:0] {LINK_IDLE, LINK_READ, LINK_WRITE} link_t;

  // How a table row gets its expected results: from the model, or typed in.
  typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_STATUS, ROW_FRAME} row_check_t;
  // Table rows may ask for the CRC of the response bytes sent so far.
  typedef enum logic [1:0] {FILL_AS_IS, FILL_CRC_LO, FILL_CRC_HI} fill_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] reg_addr;
    logic [15:0] word;
    logic [7:0]  rx_byte;
    fill_t       fill;
    row_check_t  chk;
    logic [2:0]  status;
    logic [63:0] frame;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  mrfe_in_if  in_bus();
  mrfe_out_if out_bus();

  modbus_rtu_master_frame_engine_top #(
    .MAX_WORDS(MAX_WORDS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Model of the master: its own copy of the address register and of the
  // transaction state. Every accepted input beat advances it once.
  // --------------------------------------------------------------------------
  logic [7:0]  dev_addr;
  link_t       link;
  logic [5:0]  resp_len;
  logic [5:0]  resp_seen;
  logic [4:0]  words_due;
  logic [15:0] resp_crc;
  logic        hdr_good;
  logic        crc_good;
  logic        echo_good;
  logic [7:0]  req_bytes [8];
  logic [15:0] word_buf [STORE_DEPTH];

  // Results of the latest input beat, and every result still to come out.
  result_t step_beats[$];
  result_t owed_beats[$];

  int fail_count;
  int beats_checked;
  int counted_items;
  int burst_left;
  int cycle_count;
  int status_seen [8];
  logic [7:0] reply[$];

  // Reflected CRC-16, one byte at a time, least significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
    return r;
  endfunction

  function automatic result_t mk_beat(input logic [1:0] kind, input logic [7:0] tx,
                                      input logic [15:0] rw, input logic [3:0] idx,
                                      input logic [2:0] st, input logic last);
    result_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.reg_word   = rw;
    r.word_index = idx;
    r.status     = st;
    r.last       = last;
    return r;
  endfunction

  // Builds the 8-byte request, queues it for transmit and opens a new response.
  task automatic load_request(input logic [7:0] fc, input logic [15:0] ra,
                              input logic [15:0] val);
    logic [15:0] c;
    req_bytes[0] = dev_addr;
    req_bytes[1] = fc;
    req_bytes[2] = ra[15:8];
    req_bytes[3] = ra[7:0];
    req_bytes[4] = val[15:8];
    req_bytes[5] = val[7:0];
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc16_byte(c, req_bytes[i]);
    req_bytes[6] = c[7:0];
    req_bytes[7] = c[15:8];
    for (int i = 0; i < 8; i++)
      step_beats.push_back(mk_beat(KIND_TX, req_bytes[i], 16'h0, 4'h0, ST_OK, i == 7));
    resp_seen = '0;
    resp_crc  = CRC_INIT;
    hdr_good  = 1'b1;
    crc_good  = 1'b1;
    echo_good = 1'b1;
  endtask

  // Closes a complete response. A CRC error outranks a bad header.
  task automatic close_response();
    int cnt;
    if (link == LINK_WRITE) begin
      step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0,
                                   echo_good ? ST_OK : ST_ECHO, 1'b1));
    end else if (!crc_good) begin
      step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0, ST_CRC, 1'b1));
    end else if (!hdr_good) begin
      step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0, ST_BAD_HDR, 1'b1));
    end else begin
      cnt = (int'(words_due) > STORE_DEPTH) ? STORE_DEPTH : int'(words_due);
      for (int i = 0; i < cnt; i++)
        step_beats.push_back(mk_beat(KIND_WORD, 8'h00, word_buf[i], 4'(i), ST_OK, 1'b0));
      step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0, ST_OK, 1'b1));
    end
    link = LINK_IDLE;
  endtask

  task automatic step_master(input logic [1:0] op, input logic [15:0] ra,
                             input logic [15:0] w, input logic [7:0] b);
    int pos;
    int idx;
    step_beats.delete();
    case (op)
      OP_READ: begin
        if (w == 16'd0 || w > WORD_LIMIT) begin
          // A bad count drops any pending transaction and sends no request, only a status beat.
          link = LINK_IDLE;
          step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0, ST_BAD_COUNT, 1'b1));
        end else begin
          load_request(FC_READ, ra, w);
          words_due = w[4:0];
          resp_len  = 6'(5 + 2 * w);
          link      = LINK_READ;
        end
      end
      OP_WRITE: begin
        load_request(FC_WRITE, ra, w);
        words_due = '0;
        resp_len  = 6'd8;
        link      = LINK_WRITE;
      end
      OP_TIMEOUT: begin
        if (link != LINK_IDLE) begin
          link = LINK_IDLE;
          step_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0, ST_TIMEOUT, 1'b1));
        end
      end
      default: begin
        if (link != LINK_IDLE) begin
          pos = int'(resp_seen);
          if (link == LINK_WRITE) begin
            if (req_bytes[pos % 8] != b) echo_good = 1'b0;
          end else if (pos + 2 < resp_len) begin
            resp_crc = crc16_byte(resp_crc, b);
            if (pos == 0 && b != dev_addr) hdr_good = 1'b0;
            if (pos == 1 && b != FC_READ) hdr_good = 1'b0;
            // The byte-count field at position 2 is taken without a check.
            if (pos >= 3) begin
              idx = ((pos - 3) >> 1) % STORE_DEPTH;
              if (((pos - 3) & 1) == 0) word_buf[idx] = {b, 8'h00};
              else word_buf[idx] = word_buf[idx] | {8'h00, b};
            end
          end else if (pos + 2 == resp_len) begin
            if (b != resp_crc[7:0]) crc_good = 1'b0;
          end else begin
            if (b != resp_crc[15:8]) crc_good = 1'b0;
          end
          resp_seen = 6'(pos + 1);
          if (resp_seen >= resp_len) close_response();
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock, watchdog and result checking
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results outstanding",
               $time, owed_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
      fail_count++;
    end
  endtask

  // Result beats are taken at the rising edge, where valid and ready meet.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (out_bus.kind === KIND_STATUS) status_seen[out_bus.status]++;
      if (owed_beats.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got kind %0d tx 0x%0h",
                 $time, out_bus.kind, out_bus.tx_byte);
        $display("  word 0x%0h index %0d status %0d last %0b", out_bus.reg_word,
                 out_bus.word_index, out_bus.status, out_bus.last);
        fail_count++;
      end else begin
        want = owed_beats.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_bus.kind));
        compare_field("tx_byte", 16'(want.tx_byte), 16'(out_bus.tx_byte));
        compare_field("reg_word", want.reg_word, out_bus.reg_word);
        compare_field("word_index", 16'(want.word_index), 16'(out_bus.word_index));
        compare_field("status", 16'(want.status), 16'(out_bus.status));
        compare_field("last", 16'(want.last), 16'(out_bus.last));
        beats_checked++;
      end
    end
  end

  // The result side runs through spells of different stall behavior: always
  // ready, random stalls, short periodic stalls and long periodic stalls.
  initial begin : result_sink
    int span;
    int style;
    out_bus.ready = 1'b0;
    span  = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(24, 96);
      end
      span--;
      case (style)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
        2:       out_bus.ready <= (span % 3) != 0;
        default: out_bus.ready <= (span % 12) == 0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Drives one input beat at the falling edge and holds it until accepted.
  // The sender works in bursts; between most bursts valid drops for a while,
  // and about a quarter of bursts follow on with no gap at all.
  task automatic send_item(input logic [1:0] op, input logic [15:0] ra,
                           input logic [15:0] w, input logic [7:0] b,
                           input bit use_model);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.reg_addr <= ra;
    in_bus.word     <= w;
    in_bus.rx_byte  <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    // Idle bytes and idle timeouts are dropped by the engine; they do not count.
    if (!((op == OP_BYTE || op == OP_TIMEOUT) && link == LINK_IDLE)) counted_items++;
    step_master(op, ra, w, b);
    if (use_model)
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
  endtask

  // Holds the input quiet until every awaited result has come out.
  task automatic drain_all();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Changes the slave address only with the engine idle and quiet.
  task automatic set_slave_address(input logic [7:0] addr);
    if (link != LINK_IDLE)
      send_item(OP_TIMEOUT, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    drain_all();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    dev_addr = addr;
  endtask

  // A read of random size, answered well most of the time. Other answers
  // carry a wrong address or function, a corrupted byte, or stop early and
  // are either timed out or left for the next command to abandon.
  task automatic read_exchange();
    int n;
    int v;
    int cut;
    int at;
    logic [15:0] c;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, WORD_LIMIT) : $urandom_range(1, 4);
    send_item(OP_READ, 16'($urandom), 16'(n), 8'($urandom), 1'b1);
    v = $urandom_range(0, 9);
    reply.delete();
    reply.push_back((v == 6) ? dev_addr ^ 8'($urandom_range(1, 255)) : dev_addr);
    reply.push_back((v == 7) ? FC_READ ^ (8'h01 << $urandom_range(0, 7)) : FC_READ);
    reply.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(2 * n));
    repeat (2 * n) reply.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (reply[i]) c = crc16_byte(c, reply[i]);
    reply.push_back(c[7:0]);
    reply.push_back(c[15:8]);
    if (v == 8) begin
      at = $urandom_range(0, reply.size() - 1);
      reply[at] = reply[at] ^ 8'($urandom_range(1, 255));
    end
    cut = (v == 9) ? $urandom_range(0, reply.size() - 1) : reply.size();
    for (int i = 0; i < cut; i++)
      send_item(OP_BYTE, 16'($urandom), 16'($urandom), reply[i], 1'b1);
    if (v == 9 && $urandom_range(0, 1) == 1)
      send_item(OP_TIMEOUT, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  // A write whose answer echoes the request, with the odd corrupted or cut echo.
  task automatic write_exchange();
    int v;
    int cut;
    int at;
    send_item(OP_WRITE, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    v = $urandom_range(0, 9);
    reply.delete();
    for (int i = 0; i < 8; i++) reply.push_back(req_bytes[i]);
    if (v == 7) begin
      at = $urandom_range(0, 7);
      reply[at] = reply[at] ^ 8'($urandom_range(1, 255));
    end
    cut = (v >= 8) ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < cut; i++)
      send_item(OP_BYTE, 16'($urandom), 16'($urandom), reply[i], 1'b1);
    if (v == 8) send_item(OP_TIMEOUT, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  task automatic random_exchange();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      read_exchange();
    end else if (pick < 72) begin
      write_exchange();
    end else if (pick < 80) begin
      // Count of zero, or anything past the word limit up to the field maximum.
      send_item(OP_READ, 16'($urandom),
                ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom_range(WORD_LIMIT + 1, 65535)),
                8'($urandom), 1'b1);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3))
        send_item(OP_BYTE, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    end else begin
      send_item(OP_TIMEOUT, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  row_t plan[$];

  function automatic void add_row(input logic [1:0] op, input logic [15:0] ra,
                                  input logic [15:0] w, input logic [7:0] b,
                                  input fill_t fill, input row_check_t chk,
                                  input logic [2:0] st = ST_OK,
                                  input logic [63:0] frame = 64'h0);
    row_t r;
    r.op       = op;
    r.reg_addr = ra;
    r.word     = w;
    r.rx_byte  = b;
    r.fill     = fill;
    r.chk      = chk;
    r.status   = st;
    r.frame    = frame;
    plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    logic [15:0] reply_crc;
    logic [7:0]  b;
    logic [7:0]  addr_plan [4];
    bit          paused;
    int          target;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'h00;
    in_bus.valid    = 1'b0;
    in_bus.opcode   = OP_BYTE;
    in_bus.reg_addr = 16'h0000;
    in_bus.word     = 16'h0000;
    in_bus.rx_byte  = 8'h00;

    // Model state after reset. The word buffer is only read once filled.
    dev_addr  = 8'h01;
    link      = LINK_IDLE;
    resp_len  = '0;
    resp_seen = '0;
    words_due = '0;
    resp_crc  = CRC_INIT;
    hdr_good  = 1'b0;
    crc_good  = 1'b0;
    echo_good = 1'b0;
    foreach (req_bytes[i]) req_bytes[i] = 8'h00;
    foreach (word_buf[i]) word_buf[i] = 16'h0000;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed results: idle traffic gives nothing, bad counts
    // and timeouts give one status beat, and the first request after reset
    // is the textbook frame for a one-register read from device address 1.
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'hFF, FILL_AS_IS, ROW_NONE);
    add_row(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 8'h00, FILL_AS_IS, ROW_NONE);
    add_row(OP_READ,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_STATUS, ST_BAD_COUNT);
    add_row(OP_READ,    16'hFFFF, 16'hFFFF, 8'hFF, FILL_AS_IS, ROW_STATUS, ST_BAD_COUNT);
    add_row(OP_READ,    16'h0000, 16'h0001, 8'h00, FILL_AS_IS, ROW_FRAME, ST_OK,
            64'h0103_0000_0001_840A);
    // Good one-word answer whose byte-count field is deliberately wrong.
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h01, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h03, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h55, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'hFF, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'hFF, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_CRC_LO, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_CRC_HI, ROW_MODEL);
    add_row(OP_READ,    16'h0000, 16'd17,   8'h00, FILL_AS_IS, ROW_STATUS, ST_BAD_COUNT);
    // A write, then a maximum-size read that abandons it, then a timeout.
    add_row(OP_WRITE,   16'hFFFF, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_READ,    16'h5A5A, 16'd16,   8'hFF, FILL_AS_IS, ROW_MODEL);
    add_row(OP_TIMEOUT, 16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_STATUS, ST_TIMEOUT);
    // Wrong address and wrong CRC together: the CRC error is the one reported.
    add_row(OP_READ,    16'h0000, 16'h0001, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h03, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h02, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_BYTE,    16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_WRITE,   16'hA5A5, 16'hFFFF, 8'h00, FILL_AS_IS, ROW_MODEL);
    add_row(OP_TIMEOUT, 16'h0000, 16'h0000, 8'h00, FILL_AS_IS, ROW_STATUS, ST_TIMEOUT);

    reply_crc = CRC_INIT;
    foreach (plan[i]) begin
      // CRC rows close the response with the checksum of the data bytes so far.
      b = plan[i].rx_byte;
      if (plan[i].fill == FILL_CRC_LO) b = reply_crc[7:0];
      else if (plan[i].fill == FILL_CRC_HI) b = reply_crc[15:8];
      else if (plan[i].op == OP_BYTE) reply_crc = crc16_byte(reply_crc, b);
      if (plan[i].op == OP_READ || plan[i].op == OP_WRITE) reply_crc = CRC_INIT;
      send_item(plan[i].op, plan[i].reg_addr, plan[i].word, b, plan[i].chk == ROW_MODEL);
      case (plan[i].chk)
        ROW_STATUS:
          owed_beats.push_back(mk_beat(KIND_STATUS, 8'h00, 16'h0, 4'h0,
                                       plan[i].status, 1'b1));
        ROW_FRAME:
          for (int k = 0; k < 8; k++)
            owed_beats.push_back(mk_beat(KIND_TX, plan[i].frame[63 - 8 * k -: 8], 16'h0,
                                         4'h0, ST_OK, k == 7));
        default: ;
      endcase
    end

    // Random part in four phases, each under its own slave address: both
    // extremes first, then two random ones.
    addr_plan[0] = 8'hFF;
    addr_plan[1] = 8'h00;
    addr_plan[2] = 8'($urandom);
    addr_plan[3] = 8'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      set_slave_address(addr_plan[ph]);
      target = counted_items + PHASE_ITEMS;
      while (counted_items < target) begin
        random_exchange();
        // Once, halfway through a phase, let the engine run completely dry.
        if (!paused && ph == 1 && counted_items >= target - PHASE_ITEMS / 2) begin
          drain_all();
          paused = 1'b1;
        end
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d counted input beats and %0d checked result beats over 4 addresses.",
             counted_items, beats_checked);
    $display("Status beats: ok %0d, timeout %0d, crc %0d, header %0d, echo %0d, count %0d.",
             status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_CRC],
             status_seen[ST_BAD_HDR], status_seen[ST_ECHO], status_seen[ST_BAD_COUNT]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/mrfe_pkg.sv
design/mrfe_channels.sv
design/mrfe_front.sv
design/mrfe_queue.sv
design/mrfe_back.sv
design/modbus_rtu_master_frame_engine_top.sv
dv/testbench.sv
